// ----- src/rau_pkg.sv -----
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

	localparam int OPERAND_BITS_DEF = 32;
	localparam int WIDE_W           = 64;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_MUL_C,
		ST_PREP,
		ST_GCD,
		ST_DIV,
		ST_OUT
	} st_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] a_num;
		logic        [30:0] a_den;
		logic signed [31:0] b_num;
		logic        [30:0] b_den;
	} cmd_t;

	typedef struct packed {
		logic signed [63:0] res_num;
		logic        [62:0] res_den;
		logic               div_zero;
	} res_t;

endpackage

// ----- src/rau_mul.sv -----
// Registered signed multiplier that forms the raw numerator and denominator terms.
module rau_mul #(
	parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
	input  logic                              clk,
	input  logic signed [OPERAND_BITS:0]      x,
	input  logic signed [OPERAND_BITS:0]      y,
	output logic signed [rau_pkg::WIDE_W-1:0] prod_q
);

	localparam int PW = 2 * (OPERAND_BITS + 1);

	logic signed [PW-1:0] prod;

	assign prod = x * y;

	// all products fit the wide word; resize keeps the sign
	always_ff @(posedge clk) begin
		prod_q <= rau_pkg::WIDE_W'(prod);
	end

endmodule

// ----- src/rau_sub.sv -----
// Shared subtract and compare unit used by the GCD loop and the divider.
module rau_sub (
	input  logic [rau_pkg::WIDE_W:0] a,
	input  logic [rau_pkg::WIDE_W:0] b,
	output logic [rau_pkg::WIDE_W:0] diff,
	output logic                     borrow
);

	assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

// ----- src/rational_arith_unit_top.sv -----
// Rational arithmetic unit: a op b on two fractions, reduced by their GCD.
// One word is accepted at a time and cmd_ready stays low until its result has moved to the
// output register. An item passes through the multiplier states MUL_A, MUL_B and MUL_C, then PREP,
// which fixes signs, then a binary GCD (one shift, swap or subtract per cycle), then two
// 64-step restoring divisions that divide numerator and denominator by the GCD. All loop
// steps run on one 65-bit subtractor. A zero result or a zero denominator skips the GCD
// and divisions and goes straight to the output state. Divide by a zero fraction
// returns 0/0 with div_zero set.
module rational_arith_unit_top #(
	parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  rau_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output rau_pkg::res_t res
);

	localparam int W     = rau_pkg::WIDE_W;
	localparam int CNT_W = $clog2(W);
	localparam int K_W   = $clog2(W);

	rau_pkg::st_t state_q, state_d;

	rau_pkg::op_t                  op_q;
	logic signed [OPERAND_BITS-1:0] an_q, bn_q;
	logic        [OPERAND_BITS-2:0] ad_q, bd_q;

	logic signed [OPERAND_BITS:0] mx, my;
	logic signed [W-1:0]          prod_q;
	logic signed [W-1:0]          rn_q;

	logic [W-1:0]     nm_q, dm_q, u_q, v_q, g_q, quo_q, rem_q, nq_q;
	logic [K_W-1:0]   k_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pass_q, neg_q;

	logic [W-1:0] fin_num_q;
	logic [W-2:0] fin_den_q;
	logic         fin_dz_q;

	logic          res_valid_q;
	rau_pkg::res_t res_q;

	logic [W:0] sub_a, sub_b, sub_diff;
	logic       sub_borrow;

	logic signed [OPERAND_BITS:0] an_x, bn_x, ad_x, bd_x;
	logic signed [W-1:0]          rd;
	logic [W-1:0]                 nm_mag, dm_mag;
	logic [W:0]                   trial;
	logic                         qbit;
	logic [W-1:0]                 rem_nx, quo_nx;
	logic                         out_free;

	assign an_x = (OPERAND_BITS + 1)'(an_q);
	assign bn_x = (OPERAND_BITS + 1)'(bn_q);
	assign ad_x = signed'({2'b00, ad_q});
	assign bd_x = signed'({2'b00, bd_q});

	always_comb begin
		case (state_q)
			rau_pkg::ST_MUL_A: begin
				mx = an_x;
				my = (op_q == rau_pkg::OP_MUL) ? bn_x : bd_x;
			end
			rau_pkg::ST_MUL_B: begin
				mx = bn_x;
				my = ad_x;
			end
			default: begin
				mx = ad_x;
				my = (op_q == rau_pkg::OP_DIV) ? bn_x : bd_x;
			end
		endcase
	end

	rau_mul #(
		.OPERAND_BITS(OPERAND_BITS)
	) u_mul (
		.clk   (clk),
		.x     (mx),
		.y     (my),
		.prod_q(prod_q)
	);

	assign trial = {rem_q, quo_q[W-1]};
	assign sub_a = (state_q == rau_pkg::ST_GCD) ? {1'b0, u_q} : trial;
	assign sub_b = (state_q == rau_pkg::ST_GCD) ? {1'b0, v_q} : {1'b0, g_q};

	rau_sub u_sub (
		.a     (sub_a),
		.b     (sub_b),
		.diff  (sub_diff),
		.borrow(sub_borrow)
	);

	assign qbit   = ~sub_borrow;
	assign rem_nx = qbit ? sub_diff[W-1:0] : trial[W-1:0];
	assign quo_nx = {quo_q[W-2:0], qbit};

	assign rd     = prod_q;
	assign nm_mag = rn_q[W-1] ? W'(0) - W'(rn_q) : W'(rn_q);
	assign dm_mag = rd[W-1] ? W'(0) - W'(rd) : W'(rd);

	assign out_free  = ~res_valid_q | res_ready;
	assign cmd_ready = (state_q == rau_pkg::ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rau_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rau_pkg::ST_IDLE: begin
				if (cmd_valid) state_d = rau_pkg::ST_MUL_A;
			end
			rau_pkg::ST_MUL_A: state_d = rau_pkg::ST_MUL_B;
			rau_pkg::ST_MUL_B: state_d = rau_pkg::ST_MUL_C;
			rau_pkg::ST_MUL_C: state_d = rau_pkg::ST_PREP;
			rau_pkg::ST_PREP: begin
				if (rd == '0 || nm_mag == '0) state_d = rau_pkg::ST_OUT;
				else state_d = rau_pkg::ST_GCD;
			end
			rau_pkg::ST_GCD: begin
				if (u_q == '0) state_d = rau_pkg::ST_DIV;
			end
			rau_pkg::ST_DIV: begin
				if (cnt_q == '1 && pass_q) state_d = rau_pkg::ST_OUT;
			end
			rau_pkg::ST_OUT: begin
				if (out_free) state_d = rau_pkg::ST_IDLE;
			end
			default: state_d = rau_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == rau_pkg::ST_OUT && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rau_pkg::ST_IDLE: begin
				op_q <= cmd.op;
				an_q <= cmd.a_num[OPERAND_BITS-1:0];
				ad_q <= cmd.a_den[OPERAND_BITS-2:0];
				bn_q <= cmd.b_num[OPERAND_BITS-1:0];
				bd_q <= cmd.b_den[OPERAND_BITS-2:0];
			end
			rau_pkg::ST_MUL_B: begin
				rn_q <= prod_q;
			end
			rau_pkg::ST_MUL_C: begin
				case (op_q)
					rau_pkg::OP_ADD: rn_q <= rn_q + prod_q;
					rau_pkg::OP_SUB: rn_q <= rn_q - prod_q;
					default:         rn_q <= rn_q;
				endcase
			end
			rau_pkg::ST_PREP: begin
				neg_q <= rn_q[W-1] ^ rd[W-1];
				nm_q  <= nm_mag;
				dm_q  <= dm_mag;
				u_q   <= nm_mag;
				v_q   <= dm_mag;
				k_q   <= '0;
				if (rd == '0) begin
					fin_num_q <= '0;
					fin_den_q <= '0;
					fin_dz_q  <= 1'b1;
				end else begin
					// zero value goes out as 0/1
					fin_num_q <= '0;
					fin_den_q <= (W - 1)'(1);
					fin_dz_q  <= 1'b0;
				end
			end
			rau_pkg::ST_GCD: begin
				if (u_q == '0) begin
					g_q   <= v_q << k_q;
					quo_q <= nm_q;
					rem_q <= '0;
					cnt_q <= '0;
					pass_q <= 1'b0;
				end else if (!u_q[0] && !v_q[0]) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
					k_q <= k_q + K_W'(1);
				end else if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else if (sub_borrow) begin
					// keep u the larger one before subtracting
					u_q <= v_q;
					v_q <= u_q;
				end else begin
					u_q <= sub_diff[W-1:0];
				end
			end
			rau_pkg::ST_DIV: begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == '1) begin
					if (!pass_q) begin
						nq_q   <= quo_nx;
						quo_q  <= dm_q;
						rem_q  <= '0;
						pass_q <= 1'b1;
					end else begin
						fin_num_q <= neg_q ? W'(0) - nq_q : nq_q;
						fin_den_q <= quo_nx[W-2:0];
						fin_dz_q  <= 1'b0;
					end
				end else begin
					quo_q <= quo_nx;
					rem_q <= rem_nx;
				end
			end
			rau_pkg::ST_OUT: begin
				if (out_free) begin
					res_q.res_num  <= signed'(fin_num_q);
					res_q.res_den  <= fin_den_q;
					res_q.div_zero <= fin_dz_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- bench/rational_arith_unit_top_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the rational arithmetic unit: fraction ops checked against a local model.
module rational_arith_unit_top_test;

	localparam logic signed [31:0] NUM_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] NUM_MAX = 32'sh7FFF_FFFF;
	localparam logic [30:0]        DEN_MAX = 31'h7FFF_FFFF;
	localparam int RANDOM_WORDS = 1450;
	localparam int DRAIN_EVERY  = 250;
	localparam int TAIL_CYCLES  = 400;
	localparam longint unsigned CYCLE_LIMIT = 64'd4_000_000;

	// operand flavors for the random words
	localparam int K_WIDE   = 0;
	localparam int K_TINY   = 1;
	localparam int K_SHARED = 2;
	localparam int K_CORNER = 3;

	class fraction_ledger;
		rau_pkg::res_t outstanding[$];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned zero_den_seen;

		function rau_pkg::res_t reduced_fraction(rau_pkg::cmd_t c);
			longint an, ad, bn, bd, rn, rd;
			longint unsigned nm, dm, x, y, t;
			bit neg;
			rau_pkg::res_t r;
			an = {{32{c.a_num[31]}}, c.a_num};
			bn = {{32{c.b_num[31]}}, c.b_num};
			ad = {33'd0, c.a_den};
			bd = {33'd0, c.b_den};
			case (c.op)
				rau_pkg::OP_ADD: begin rn = an * bd + bn * ad; rd = ad * bd; end
				rau_pkg::OP_SUB: begin rn = an * bd - bn * ad; rd = ad * bd; end
				rau_pkg::OP_MUL: begin rn = an * bn; rd = ad * bd; end
				default: begin rn = an * bd; rd = ad * bn; end
			endcase
			if (rd == 0) begin
				r.res_num = '0;
				r.res_den = '0;
				r.div_zero = 1'b1;
				return r;
			end
			neg = (rn < 0) != (rd < 0);
			nm = (rn < 0) ? -rn : rn;
			dm = (rd < 0) ? -rd : rd;
			x = nm;
			y = dm;
			while (y != 0) begin
				t = x % y;
				x = y;
				y = t;
			end
			nm = nm / x;
			dm = dm / x;
			if (nm == 0)
				neg = 1'b0;
			r.res_num = neg ? -nm : nm;
			r.res_den = dm[62:0];
			r.div_zero = 1'b0;
			return r;
		endfunction

		function void note_cmd(rau_pkg::cmd_t c);
			outstanding.push_back(reduced_fraction(c));
		endfunction

		function int pending();
			return outstanding.size();
		endfunction

		task report_mismatch(string what);
			$display("[%0t] error: %s", $time, what);
			mismatches++;
		endtask

		task check_res(rau_pkg::res_t got);
			rau_pkg::res_t want;
			if (outstanding.size() == 0) begin
				report_mismatch($sformatf("unrequested result %0d/%0d dz=%0b",
					got.res_num, got.res_den, got.div_zero));
				return;
			end
			want = outstanding.pop_front();
			checked++;
			if (want.div_zero)
				zero_den_seen++;
			if (got.res_num !== want.res_num)
				report_mismatch($sformatf("res_num %0d, want %0d", got.res_num, want.res_num));
			if (got.res_den !== want.res_den)
				report_mismatch($sformatf("res_den %0d, want %0d", got.res_den, want.res_den));
			if (got.div_zero !== want.div_zero)
				report_mismatch($sformatf("div_zero %0b, want %0b", got.div_zero, want.div_zero));
		endtask
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	rau_pkg::cmd_t cmd = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	rau_pkg::res_t res;

	fraction_ledger ledger = new;
	longint unsigned cycles = 0;
	int unsigned op_count[4] = '{0, 0, 0, 0};

	rational_arith_unit_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results outstanding", cycles, ledger.pending());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// mostly back to back, sometimes a short pause, rarely a long one
	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [31:0] pick_num(int kind, int unsigned f);
		logic signed [31:0] v;
		case (kind)
			K_WIDE: v = $urandom();
			K_TINY: v = $urandom_range(0, 64);
			K_SHARED: v = f * $urandom_range(0, 400000);
			default: begin
				case ($urandom_range(0, 4))
					0: v = NUM_MIN;
					1: v = NUM_MAX;
					2: v = -1;
					3: v = 0;
					default: v = 1;
				endcase
			end
		endcase
		if (kind != K_WIDE && $urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	function automatic logic [30:0] pick_den(int kind, int unsigned f);
		logic [30:0] d;
		case (kind)
			K_WIDE: d = 31'($urandom());
			K_TINY: d = 31'($urandom_range(1, 64));
			K_SHARED: d = 31'(f * $urandom_range(1, 400000));
			default: begin
				case ($urandom_range(0, 3))
					0: d = 1;
					1: d = DEN_MAX;
					2: d = DEN_MAX - 31'd1;
					default: d = 31'($urandom_range(1, 3));
				endcase
			end
		endcase
		return d;
	endfunction

	function automatic rau_pkg::cmd_t random_cmd();
		rau_pkg::cmd_t c;
		int r, ka, kb;
		int unsigned f;
		r = $urandom_range(0, 99);
		if (r < 35)
			ka = K_WIDE;
		else if (r < 70)
			ka = K_TINY;
		else if (r < 90)
			ka = K_SHARED;
		else
			ka = K_CORNER;
		kb = ($urandom_range(0, 3) == 0) ? $urandom_range(K_WIDE, K_CORNER) : ka;
		f = $urandom_range(1, 5000);
		c.op = rau_pkg::op_t'($urandom_range(0, 3));
		c.a_num = pick_num(ka, f);
		c.a_den = pick_den(ka, f);
		c.b_num = pick_num(kb, f);
		c.b_den = pick_den(kb, f);
		// zero divisor fractions, mostly under a divide
		if ($urandom_range(0, 24) == 0) begin
			c.b_num = 0;
			if ($urandom_range(0, 2) != 0)
				c.op = rau_pkg::OP_DIV;
		end
		if ($urandom_range(0, 49) == 0) begin
			if ($urandom_range(0, 1))
				c.a_den = 0;
			else
				c.b_den = 0;
		end
		return c;
	endfunction

	task automatic send_word(input rau_pkg::cmd_t c);
		int gap;
		cmd <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (!cmd_ready);
		ledger.note_cmd(c);
		op_count[c.op]++;
		gap = idle_span();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic issue(input rau_pkg::op_t op, input logic signed [31:0] an,
			input logic [30:0] ad, input logic signed [31:0] bn, input logic [30:0] bd);
		rau_pkg::cmd_t c;
		c.op = op;
		c.a_num = an;
		c.a_den = ad;
		c.b_num = bn;
		c.b_den = bd;
		send_word(c);
	endtask

	task automatic hold_until_drained();
		if (cmd_valid)
			cmd_valid <= 1'b0;
		while (ledger.pending() != 0) @(posedge clk);
	endtask

	// result side: random stalls, with long stretches of steady ready
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && res_ready)
				ledger.check_res(res);
			if (hold > 0) begin
				hold--;
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: begin
						res_ready <= 1'b1;
						hold = $urandom_range(0, 24);
					end
					6, 7, 8: begin
						res_ready <= 1'b0;
						hold = idle_span() + $urandom_range(0, 40);
					end
					default: begin
						res_ready <= 1'b1;
						hold = 300;
					end
				endcase
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(rau_pkg::OP_ADD, 1, 2, 1, 3);
		issue(rau_pkg::OP_SUB, 1, 2, 1, 2);
		issue(rau_pkg::OP_MUL, 2, 3, 3, 4);
		issue(rau_pkg::OP_DIV, 1, 2, 1, 4);
		issue(rau_pkg::OP_DIV, 5, 7, 0, 9);
		issue(rau_pkg::OP_DIV, 3, 5, -7, 2);
		issue(rau_pkg::OP_ADD, NUM_MAX, 1, NUM_MAX, 1);
		issue(rau_pkg::OP_SUB, NUM_MIN, 1, NUM_MAX, 1);
		issue(rau_pkg::OP_MUL, NUM_MIN, DEN_MAX, NUM_MIN, DEN_MAX);
		issue(rau_pkg::OP_DIV, NUM_MIN, DEN_MAX, NUM_MIN, 1);
		issue(rau_pkg::OP_ADD, 1, DEN_MAX, 1, DEN_MAX - 31'd1);
		issue(rau_pkg::OP_ADD, 4, 0, 3, 5);
		issue(rau_pkg::OP_MUL, 4, 7, 3, 0);
		issue(rau_pkg::OP_MUL, 0, 5, 7, 3);
		issue(rau_pkg::OP_DIV, 0, 3, 5, 7);
		issue(rau_pkg::OP_SUB, -1, 1, NUM_MAX, DEN_MAX);
		issue(rau_pkg::OP_MUL, NUM_MIN, 1, NUM_MAX, 1);
		issue(rau_pkg::OP_DIV, NUM_MAX, DEN_MAX, -1, 1);
		issue(rau_pkg::OP_ADD, -1, DEN_MAX, 1, DEN_MAX);
		issue(rau_pkg::OP_DIV, 0, 1, NUM_MIN, DEN_MAX);
		issue(rau_pkg::OP_SUB, NUM_MAX, DEN_MAX, NUM_MIN, DEN_MAX);
		hold_until_drained();

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			send_word(random_cmd());
			if (i % DRAIN_EVERY == DRAIN_EVERY - 1)
				hold_until_drained();
		end
		hold_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (ledger.pending() != 0)
			ledger.report_mismatch($sformatf("%0d results never arrived", ledger.pending()));
		$display("words sent: add %0d, sub %0d, mul %0d, div %0d; %0d results checked",
			op_count[rau_pkg::OP_ADD], op_count[rau_pkg::OP_SUB],
			op_count[rau_pkg::OP_MUL], op_count[rau_pkg::OP_DIV], ledger.checked);
		$display("zero-denominator results: %0d; field mismatches: %0d",
			ledger.zero_den_seen, ledger.mismatches);
		if (ledger.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
